[rtl/tac_pkg.sv]
// ----------------------------------------------------------------------------
// tac_pkg: shared widths, defaults and register indexes
// Constants used by the touch averaging / affine calibration block and its
// iterative divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tac_pkg;

    // sample fields
    localparam int RAW_X_W = 15;
    localparam int RAW_Y_W = 16;

    // running sums, wrap at these widths
    localparam int SUM_X_W = 17;
    localparam int SUM_Y_W = 18;
    localparam int CNT_W   = 3;

    // calibration registers
    localparam int COEF_W    = 32;
    localparam int DIVISOR_W = 31;
    localparam int CFG_IDX_W = 3;

    // numerator: |off + c*ax + c*ay| < 2^50, so 52 bits signed is ample
    localparam int ACC_W = 52;
    localparam int MAG_W = ACC_W - 1;

    // averaging
    localparam int AVG_SAMPLES_DEF = 4;
    localparam int RECIP_SHIFT     = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_DIVISOR  = 3'd6
    } cfg_reg_t;

endpackage

[rtl/touch_average_affine_calibrate.sv]
// ----------------------------------------------------------------------------
// touch_average_affine_calibrate: touch sample averager with affine calibration
// A release is registered in the cycle after its sample transfer. A press
// follows the last averaged sample: ST_AVG, then per axis ST_MUL_A, ST_MUL_B,
// ST_ACC, ST_START and the bit-serial divider in ST_WAIT, then ST_OUT.
// Throughput: one sample per cycle while averaging and output free; blocked during calibration.
// Reset (aresetn low, sync): idle, sums cleared, coefficients to identity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_average_affine_calibrate #(
    parameter int AVG_SAMPLES = tac_pkg::AVG_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tac_pkg::COEF_W-1:0]     cfg_wdata,

    // raw sample channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tac_pkg::RAW_X_W-1:0]    s_raw_x,
    input  logic [tac_pkg::RAW_Y_W-1:0]    s_raw_y,
    input  logic                           s_pen_down,

    // press / release channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_is_press,
    output logic signed [tac_pkg::COEF_W-1:0] m_screen_x,
    output logic signed [tac_pkg::COEF_W-1:0] m_screen_y
);

    import tac_pkg::*;

    // Averaging divides by AVG_SAMPLES through a constant reciprocal:
    // floor(s/N) = (s * ceil(2^K/N)) >> K, exact for all 18-bit sums.
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int PX_W = SUM_X_W + RECIP_W;
    localparam int PY_W = SUM_Y_W + RECIP_W;
    localparam int MUL_W = COEF_W + SUM_Y_W + 1;

    // saturation limits on the quotient magnitude
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(64'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(64'h8000_0000);

    // Sequencer: per axis the shared multiplier runs twice, the adder
    // accumulates, then the divider produces the quotient.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_AVG   = 8'b0000_0010,
        ST_MUL_A = 8'b0000_0100,
        ST_MUL_B = 8'b0000_1000,
        ST_ACC   = 8'b0001_0000,
        ST_START = 8'b0010_0000,
        ST_WAIT  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // calibration registers
    logic signed [COEF_W-1:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic signed [COEF_W-1:0] coef_yx_reg, coef_yy_reg, offset_y_reg;
    logic [DIVISOR_W-1:0]     divisor_reg;

    // collection state
    logic                 collecting_reg, collecting_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_X_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_Y_W-1:0]   sum_y_reg, sum_y_next;

    // datapath
    logic [SUM_X_W-1:0]       avg_x_reg, avg_x_next;
    logic [SUM_Y_W-1:0]       avg_y_reg, avg_y_next;
    logic [PX_W-1:0]          avg_x_prod;
    logic [PY_W-1:0]          avg_y_prod;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic                     axis_reg, axis_next;
    logic                     neg_reg, neg_next;
    logic signed [COEF_W-1:0] res_x_reg, res_x_next;

    // shared multiplier operands
    logic signed [COEF_W-1:0] mul_coef;
    logic [SUM_Y_W-1:0]       mul_avg;
    logic signed [MUL_W-1:0]  mul_res;

    // divider hookup
    logic                 div_start;
    logic                 div_done;
    logic [MAG_W-1:0]     div_numer;
    logic [MAG_W-1:0]     div_quot;
    logic [DIVISOR_W-1:0] div_denom;
    logic signed [COEF_W-1:0] sat_val;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic                     m_is_press_reg, m_is_press_next;
    logic signed [COEF_W-1:0] m_screen_x_reg, m_screen_x_next;
    logic signed [COEF_W-1:0] m_screen_y_reg, m_screen_y_next;

    logic out_free;
    logic s_xfer;
    logic last_sample;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_xx_reg  <= COEF_W'(1);
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= COEF_W'(1);
            offset_y_reg <= '0;
            divisor_reg  <= DIVISOR_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF_XX:  coef_xx_reg  <= cfg_wdata;
                REG_COEF_XY:  coef_xy_reg  <= cfg_wdata;
                REG_OFFSET_X: offset_x_reg <= cfg_wdata;
                REG_COEF_YX:  coef_yx_reg  <= cfg_wdata;
                REG_COEF_YY:  coef_yy_reg  <= cfg_wdata;
                REG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                REG_DIVISOR:  divisor_reg  <= cfg_wdata[DIVISOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // The output register frees up when its transfer happens, so a new
    // sample can be taken in the same cycle a result leaves.
    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = (state_reg == ST_IDLE) & out_free;
    assign s_xfer   = s_valid & s_ready;

    assign last_sample = (count_reg + CNT_W'(1)) == CNT_W'(AVG_SAMPLES);

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign avg_x_prod = PX_W'(sum_x_reg) * PX_W'(RECIP);
    assign avg_y_prod = PY_W'(sum_y_reg) * PY_W'(RECIP);

    // coefficient select: first pass uses the raw-x weight, second the raw-y
    always_comb begin
        if (state_reg == ST_MUL_A) begin
            mul_coef = axis_reg ? coef_yx_reg : coef_xx_reg;
            mul_avg  = SUM_Y_W'(avg_x_reg);
        end else begin
            mul_coef = axis_reg ? coef_yy_reg : coef_xy_reg;
            mul_avg  = avg_y_reg;
        end
    end

    assign mul_res = mul_coef * $signed({1'b0, mul_avg});

    // magnitude into the divider, sign kept aside; zero divisor acts as one
    assign div_numer = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
    assign div_denom = (divisor_reg == '0) ? DIVISOR_W'(1) : divisor_reg;
    assign div_start = (state_reg == ST_START);

    // truncate toward zero, then clamp to signed 32 bits
    always_comb begin
        if (neg_reg) begin
            sat_val = (div_quot > NEG_LIMIT) ? $signed(32'h8000_0000)
                                             : -$signed(div_quot[COEF_W-1:0]);
        end else begin
            sat_val = (div_quot > POS_LIMIT) ? $signed(32'h7FFF_FFFF)
                                             : $signed(div_quot[COEF_W-1:0]);
        end
    end

    tac_divider #(
        .NUM_W (MAG_W),
        .DEN_W (DIVISOR_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        collecting_next = collecting_reg;
        count_next      = count_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        avg_x_next      = avg_x_reg;
        avg_y_next      = avg_y_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        axis_next       = axis_reg;
        neg_next        = neg_reg;
        res_x_next      = res_x_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_is_press_next = m_is_press_reg;
        m_screen_x_next = m_screen_x_reg;
        m_screen_y_next = m_screen_y_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (!collecting_reg) begin
                        if (s_pen_down) begin
                            // start sample opens a collection, not summed
                            collecting_next = 1'b1;
                            count_next      = '0;
                            sum_x_next      = '0;
                            sum_y_next      = '0;
                        end else begin
                            // idle pen-up: release
                            m_valid_next    = 1'b1;
                            m_is_press_next = 1'b0;
                            m_screen_x_next = '0;
                            m_screen_y_next = '0;
                        end
                    end else begin
                        sum_x_next = sum_x_reg + SUM_X_W'(s_raw_x);
                        sum_y_next = sum_y_reg + SUM_Y_W'(s_raw_y);
                        if (last_sample) begin
                            collecting_next = 1'b0;
                            count_next      = '0;
                            axis_next       = 1'b0;
                            state_next      = ST_AVG;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_AVG: begin
                avg_x_next = avg_x_prod[RECIP_SHIFT +: SUM_X_W];
                avg_y_next = avg_y_prod[RECIP_SHIFT +: SUM_Y_W];
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                prod_next  = ACC_W'(mul_res);
                acc_next   = ACC_W'(axis_reg ? offset_y_reg : offset_x_reg);
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                prod_next  = ACC_W'(mul_res);
                acc_next   = acc_reg + prod_reg;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg + prod_reg;
                state_next = ST_START;
            end
            ST_START: begin
                neg_next   = acc_reg[ACC_W-1];
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    if (!axis_reg) begin
                        res_x_next = sat_val;
                        axis_next  = 1'b1;
                        state_next = ST_MUL_A;
                    end else begin
                        m_screen_y_next = sat_val;
                        state_next      = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_is_press_next = 1'b1;
                    m_screen_x_next = res_x_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            axis_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            axis_reg       <= axis_next;
            m_valid_reg    <= m_valid_next;
        end
        avg_x_reg      <= avg_x_next;
        avg_y_reg      <= avg_y_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_x_reg      <= res_x_next;
        m_is_press_reg <= m_is_press_next;
        m_screen_x_reg <= m_screen_x_next;
        m_screen_y_reg <= m_screen_y_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_press = m_is_press_reg;
    assign m_screen_x = m_screen_x_reg;
    assign m_screen_y = m_screen_y_reg;

endmodule

[rtl/tac_divider.sv]
// ----------------------------------------------------------------------------
// tac_divider: iterative unsigned restoring divider
// One quotient bit per cycle. done pulses for one cycle with the quotient
// valid on quot. denom must hold while busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tac_divider #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, denom};
    assign ge      = ~diff[DEN_W+1];

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = numer;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[verif/tb_touch_average_affine_calibrate.sv]
// ----------------------------------------------------------------------------
// tb_touch_average_affine_calibrate: self-checking bench for the touch averager
// Drives raw touch samples through a valid/ready driver fed from a queue.
// A predictor tracks the collection state and the calibration registers and
// works out each press/release event; a monitor checks every result transfer
// in order. Phases cycle through calibration settings (extremes included) and
// through idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_average_affine_calibrate;

    import tac_pkg::*;

    localparam int AVG_SAMPLES  = AVG_SAMPLES_DEF;
    localparam int RAW_X_MAX    = (1 << RAW_X_W) - 1;
    localparam int RAW_Y_MAX    = (1 << RAW_Y_W) - 1;
    localparam int PHASES       = 8;
    localparam int ITEMS_PER_PH = 170;
    // pad before config writes and at the end
    localparam int LATENCY_PAD  = 200;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -SAT_HI - 1;

    // index outside the register map; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [RAW_X_W-1:0] raw_x;
        logic [RAW_Y_W-1:0] raw_y;
        logic               pen_down;
    } touch_sample_t;

    typedef struct packed {
        logic                     is_press;
        logic signed [COEF_W-1:0] screen_x;
        logic signed [COEF_W-1:0] screen_y;
    } touch_event_t;

    // ------------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index  = REG_COEF_XX;
    logic [COEF_W-1:0]        cfg_wdata  = '0;

    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [RAW_X_W-1:0]       s_raw_x    = '0;
    logic [RAW_Y_W-1:0]       s_raw_y    = '0;
    logic                     s_pen_down = 1'b0;

    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic                     m_is_press;
    logic signed [COEF_W-1:0] m_screen_x;
    logic signed [COEF_W-1:0] m_screen_y;

    always #2 aclk = ~aclk;

    touch_average_affine_calibrate #(
        .AVG_SAMPLES (AVG_SAMPLES)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_raw_x    (s_raw_x),
        .s_raw_y    (s_raw_y),
        .s_pen_down (s_pen_down),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_press (m_is_press),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    touch_sample_t samples_to_send [$];   // filled by the sequence, drained by driver
    touch_event_t  touch_events_due [$];  // predicted events, oldest first

    // predictor copy of calibration registers and collection state
    logic [COEF_W-1:0]  cal_reg [0:REG_DIVISOR];
    logic               pred_collecting = 1'b0;
    logic [CNT_W-1:0]   pred_count      = '0;
    logic [SUM_X_W-1:0] pred_sum_x      = '0;
    logic [SUM_Y_W-1:0] pred_sum_y      = '0;

    // generator-side view: samples still owed to an open collection
    int gen_left = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int long_hold_req  = 0;
    int long_hold_seen = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // (off + cx*ax + cy*ay) / divisor, truncated toward zero, saturated to 32b
    function automatic logic signed [COEF_W-1:0] calibrate_axis(
        logic [COEF_W-1:0] off, logic [COEF_W-1:0] cx, logic [COEF_W-1:0] cy,
        logic [DIVISOR_W-1:0] divisor, longint ax, longint ay);
        longint num;
        longint dv;
        longint q;
        num = longint'($signed(off)) + longint'($signed(cx)) * ax
            + longint'($signed(cy)) * ay;
        dv  = longint'(divisor);
        if (dv == 0)
            dv = 1;             // zero divisor behaves as one
        q = num / dv;
        if (q > SAT_HI)
            q = SAT_HI;
        if (q < SAT_LO)
            q = SAT_LO;
        return q[COEF_W-1:0];
    endfunction

    // advance the predictor by one accepted sample, queue any event it causes
    function automatic void predict_touch(touch_sample_t smp);
        touch_event_t ev;
        longint ax;
        longint ay;
        if (!pred_collecting) begin
            if (smp.pen_down) begin
                // pen down while idle opens a collection; this sample isn't summed
                pred_collecting = 1'b1;
                pred_count      = '0;
                pred_sum_x      = '0;
                pred_sum_y      = '0;
            end else begin
                ev.is_press = 1'b0;
                ev.screen_x = '0;
                ev.screen_y = '0;
                touch_events_due.push_back(ev);
            end
            return;
        end
        // collected samples are summed regardless of their own pen bit
        pred_sum_x = pred_sum_x + SUM_X_W'(smp.raw_x);
        pred_sum_y = pred_sum_y + SUM_Y_W'(smp.raw_y);
        pred_count = pred_count + 1'b1;
        if (pred_count < CNT_W'(AVG_SAMPLES))
            return;
        ax = longint'(pred_sum_x / SUM_X_W'(AVG_SAMPLES));
        ay = longint'(pred_sum_y / SUM_Y_W'(AVG_SAMPLES));
        ev.is_press = 1'b1;
        ev.screen_x = calibrate_axis(cal_reg[REG_OFFSET_X], cal_reg[REG_COEF_XX],
                                     cal_reg[REG_COEF_XY],
                                     cal_reg[REG_DIVISOR][DIVISOR_W-1:0], ax, ay);
        ev.screen_y = calibrate_axis(cal_reg[REG_OFFSET_Y], cal_reg[REG_COEF_YX],
                                     cal_reg[REG_COEF_YY],
                                     cal_reg[REG_DIVISOR][DIVISOR_W-1:0], ax, ay);
        touch_events_due.push_back(ev);
        pred_collecting = 1'b0;
        pred_count      = '0;
        pred_sum_x      = '0;
        pred_sum_y      = '0;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // reading in [0, top], with the two ends favored
    function automatic int unsigned rand_reading(int unsigned top);
        case ($urandom_range(9))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    // calibration word: extremes, small signed values, or anything
    function automatic logic [COEF_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4:    return $urandom_range(2000) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_sample(int unsigned x, int unsigned y, bit down);
        touch_sample_t smp;
        smp.raw_x    = RAW_X_W'(x);
        smp.raw_y    = RAW_Y_W'(y);
        smp.pen_down = down;
        samples_to_send.push_back(smp);
        // mirror the block's collection state so sequences can be shaped
        if (gen_left != 0)
            gen_left--;
        else if (down)
            gen_left = AVG_SAMPLES;
    endfunction

    // mostly complete press sequences and releases, some raw noise;
    // any collection left open by noise is finished before returning
    function automatic void queue_random(int count);
        int made;
        int pick;
        made = 0;
        while (made < count) begin
            pick = int'($urandom_range(99));
            if (gen_left != 0 || pick >= 85) begin
                queue_sample(rand_reading(RAW_X_MAX), rand_reading(RAW_Y_MAX),
                             1'($urandom_range(1)));
                made++;
            end else if (pick < 60) begin
                queue_sample(rand_reading(RAW_X_MAX), rand_reading(RAW_Y_MAX), 1'b1);
                repeat (AVG_SAMPLES)
                    queue_sample(rand_reading(RAW_X_MAX), rand_reading(RAW_Y_MAX),
                                 $urandom_range(3) != 0);
                made += AVG_SAMPLES + 1;
            end else begin
                queue_sample(rand_reading(RAW_X_MAX), rand_reading(RAW_Y_MAX), 1'b0);
                made++;
            end
        end
        while (gen_left != 0)
            queue_sample(rand_reading(RAW_X_MAX), rand_reading(RAW_Y_MAX),
                         1'($urandom_range(1)));
    endfunction

    // everything offered has been taken and every predicted event has come;
    // sampled at the falling edge so all edge updates have settled
    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (samples_to_send.size() != 0 || s_valid || touch_events_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // sample driver: holds payload until transfer, then offers the next
    // queued sample unless this cycle is randomly left idle
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_samples
        touch_sample_t offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_touch('{s_raw_x, s_raw_y, s_pen_down});
            if (!s_valid || s_ready) begin
                if (samples_to_send.size() != 0
                    && int'($urandom_range(99)) >= send_idle_pct) begin
                    offer      = samples_to_send.pop_front();
                    s_valid    <= 1'b1;
                    s_raw_x    <= offer.raw_x;
                    s_raw_y    <= offer.raw_y;
                    s_pen_down <= offer.pen_down;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result-side ready: random stalls, plus a long hold-off on request that
    // backs the block up while the driver keeps offering
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (long_hold_seen != long_hold_req) begin
            long_hold_seen <= long_hold_req;
            hold_left      <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= int'($urandom_range(99)) >= recv_stall_pct;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each result transfer against the oldest predicted event
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_events
        touch_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (touch_events_due.size() == 0) begin
                $error("unexpected event: is_press %0d x %0d y %0d",
                       m_is_press, m_screen_x, m_screen_y);
                error_count++;
            end else begin
                want = touch_events_due.pop_front();
                if (m_is_press !== want.is_press) begin
                    $error("is_press: expected %0d, got %0d", want.is_press, m_is_press);
                    error_count++;
                end
                if (m_screen_x !== want.screen_x) begin
                    $error("screen_x: expected %0d, got %0d", want.screen_x, m_screen_x);
                    error_count++;
                end
                if (m_screen_y !== want.screen_y) begin
                    $error("screen_y: expected %0d, got %0d", want.screen_y, m_screen_y);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_touch_average_affine_calibrate: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [COEF_W-1:0] word [0:REG_DIVISOR];

        // predictor registers start at the block's reset values (identity)
        cal_reg[REG_COEF_XX]  = 32'd1;
        cal_reg[REG_COEF_XY]  = '0;
        cal_reg[REG_OFFSET_X] = '0;
        cal_reg[REG_COEF_YX]  = '0;
        cal_reg[REG_COEF_YY]  = 32'd1;
        cal_reg[REG_OFFSET_Y] = '0;
        cal_reg[REG_DIVISOR]  = 32'd1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset calibration, no idling
        // release from idle at full-scale readings
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b0);
        // full-scale press; collected pen bits mixed, they must not matter
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b1);
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b0);
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b1);
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b0);
        queue_sample(RAW_X_MAX, RAW_Y_MAX, 1'b1);
        // all-zero press
        queue_sample(0, 0, 1'b1);
        queue_sample(0, 0, 1'b0);
        queue_sample(0, 0, 1'b0);
        queue_sample(0, 0, 1'b1);
        queue_sample(0, 0, 1'b0);
        queue_sample(0, 0, 1'b0);
        // averages that floor: x sum 3 -> 0, y sum 11 -> 2
        queue_sample(RAW_X_MAX, 0, 1'b1);
        queue_sample(1, 3, 1'b0);
        queue_sample(2, 3, 1'b1);
        queue_sample(0, 3, 1'b0);
        queue_sample(0, 2, 1'b1);
        wait_quiet();
        repeat (LATENCY_PAD) @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int i = REG_COEF_XX; i <= REG_DIVISOR; i++)
                word[i] = rand_word();
            case (ph)
                0: begin
                    // plausible panel calibration, 16-bit fraction divisor
                    word[REG_COEF_XX] = $urandom_range(90000, 40000);
                    word[REG_COEF_XY] = $urandom_range(2000) - 32'd1000;
                    word[REG_COEF_YX] = $urandom_range(2000) - 32'd1000;
                    word[REG_COEF_YY] = $urandom_range(90000, 40000);
                    word[REG_DIVISOR] = 32'd65536;
                end
                1: begin
                    // everything max: positive saturation
                    foreach (word[i])
                        word[i] = 32'h7FFF_FFFF;
                    word[REG_DIVISOR] = 32'd1;
                end
                2: begin
                    // everything min: negative saturation
                    foreach (word[i])
                        word[i] = 32'h8000_0000;
                    word[REG_DIVISOR] = 32'd1;
                end
                3: word[REG_DIVISOR] = '0;                // zero divisor acts as one
                4: word[REG_DIVISOR] = 32'hFFFF_FFFF;     // top bit dropped: max divisor
                5: word[REG_DIVISOR] = $urandom_range(1000, 1);
                6: word[REG_DIVISOR] = $urandom();
                default: begin
                    // constant output from the offsets alone
                    word[REG_COEF_XX]  = '0;
                    word[REG_COEF_XY]  = '0;
                    word[REG_COEF_YX]  = '0;
                    word[REG_COEF_YY]  = '0;
                    word[REG_OFFSET_X] = 32'h8000_0000;
                    word[REG_OFFSET_Y] = 32'h7FFF_FFFF;
                    word[REG_DIVISOR]  = 32'd1;
                end
            endcase

            // register writes, back to back, with the block idle
            for (int i = REG_COEF_XX; i <= REG_DIVISOR; i++) begin
                @(posedge aclk);
                cfg_wr_en  <= 1'b1;
                cfg_index  <= CFG_IDX_W'(i);
                cfg_wdata  <= word[i];
                cal_reg[i] = word[i];
            end
            if (ph == 3) begin
                // write to an unmapped index; predictor leaves everything alone
                @(posedge aclk);
                cfg_index <= REG_UNMAPPED;
                cfg_wdata <= $urandom();
            end
            @(posedge aclk);
            cfg_wr_en <= 1'b0;

            // rotate idle patterns: none, sender idle, receiver stall, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase

            queue_random(ITEMS_PER_PH / 2);
            if (ph == 4)
                long_hold_req = long_hold_req + 1;  // back up the block while driving
            // sender pauses mid-phase until every predicted event is out
            wait_quiet();
            queue_random(ITEMS_PER_PH / 2);
            wait_quiet();
            repeat (LATENCY_PAD) @(posedge aclk);
        end

        if (error_count == 0 && touch_events_due.size() == 0)
            $display("tb_touch_average_affine_calibrate: clean");
        else
            $display("tb_touch_average_affine_calibrate: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/tac_pkg.sv
rtl/tac_divider.sv
rtl/touch_average_affine_calibrate.sv
verif/tb_touch_average_affine_calibrate.sv
